// ===== rtl/ncev_pkg.sv =====
// ----------------------------------------------------------------------------
// ncev_pkg
// Shared types, codes and helpers for the NURBS curve evaluator.
// ----------------------------------------------------------------------------
package ncev_pkg;

    localparam int ADDR_W = 11;
    localparam int DIDX_W = 3;
    localparam int SATW   = 96;

    localparam logic [1:0] OP_WR_KNOT  = 2'd0;
    localparam logic [1:0] OP_WR_POINT = 2'd1;
    localparam logic [1:0] OP_EVAL     = 2'd2;
    localparam logic [1:0] OP_DERIV    = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO_DIV = 2'd1;
    localparam logic [1:0] STAT_SAT      = 2'd2;

    localparam logic CFG_DEGREE = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    localparam logic [2:0] DEGREE_RST = 3'd3;
    localparam logic [6:0] COUNT_RST  = 7'd4;

    typedef struct packed {
        logic        [1:0]  operation;
        logic        [6:0]  entry_index;
        logic signed [31:0] knot_value;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic signed [31:0] coord_weight;
        logic signed [31:0] curve_param;
    } ncev_in_t;

    typedef struct packed {
        logic signed [31:0] result_x;
        logic signed [31:0] result_y;
        logic signed [31:0] result_z;
        logic signed [31:0] result_weight;
        logic        [6:0]  found_span;
        logic        [1:0]  status;
    } ncev_out_t;

    typedef enum logic [4:0] {
        DP_NOP, DP_LOAD, DP_WRITE, DP_NB_INIT, DP_SET_LEFT, DP_SET_RIGHT,
        DP_BDIV, DP_TSAVE, DP_NB_UPD, DP_SAVED, DP_NB_TOP, DP_KLO, DP_KD,
        DP_DDIV, DP_QSAVE, DP_ACC, DP_OUT
    } dp_op_t;

    typedef enum logic [2:0] {
        MS_RT, MS_LT, MS_NB_CP, MS_NB_Q, MS_DIFF
    } mul_sel_t;

    typedef struct packed {
        dp_op_t              op;
        logic                krd;
        logic [ADDR_W-1:0]   kaddr;
        logic                crd;
        logic [ADDR_W-1:0]   caddr;
        logic                mul_en;
        mul_sel_t            msel;
        logic [DIDX_W-1:0]   lidx;
        logic [DIDX_W-1:0]   ridx;
        logic [DIDX_W-1:0]   nidx;
        logic [1:0]          comp;
        logic [DIDX_W-1:0]   deg;
        logic [ADDR_W-1:0]   span;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       u_lt_knot;
        logic       u_le_knot;
        logic       den_zero;
        logic       kd_zero;
        logic       div_done;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_WRITE, S_SPAN_HI, S_SPAN_CHK, S_SRCH_RD, S_SRCH_CMP,
        S_NB_INIT, S_LR_RD, S_LEFT, S_RIGHT, S_BDIV, S_BDIV_WAIT, S_BTSAVE,
        S_BMUL_R, S_BNB, S_BSAVED, S_BTOP, S_PT_RD, S_PT_MUL, S_PT_ACC,
        S_DK_RD, S_DK_LO, S_DK_KD, S_DM_DIFF, S_DM_DIV, S_DM_WAIT, S_DM_QSAVE,
        S_DM_MUL, S_DM_ACC, S_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [SATW-1:0] v);
        sat_t s;
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[SATW-1:31];
        hi_zeros = ~|v[SATW-1:31];
        s.ovf = !(hi_ones || hi_zeros);
        if (s.ovf) begin
            s.val = v[SATW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            s.val = v[31:0];
        end
        return s;
    endfunction

endpackage

// ===== rtl/ncev_div.sv =====
// ----------------------------------------------------------------------------
// ncev_div
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module ncev_div #(
    parameter int NUMW = 52,
    parameter int DENW = 34
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [NUMW-1:0] num,
    input  logic signed [DENW-1:0] den,
    output logic                   done,
    output logic signed [NUMW-1:0] quot
);

    localparam int CW = $clog2(NUMW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [NUMW-1:0] nmag_reg, nmag_next;
    logic [DENW-1:0] dmag_reg, dmag_next;
    logic [DENW-1:0] rem_reg, rem_next;
    logic            neg_reg, neg_next;
    logic signed [NUMW-1:0] quot_reg, quot_next;
    logic [DENW:0]   trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        nmag_reg <= nmag_next;
        dmag_reg <= dmag_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        nmag_next = nmag_reg;
        dmag_next = dmag_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        trial     = {rem_reg, nmag_reg[NUMW-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(NUMW);
            nmag_next = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
            dmag_next = den[DENW-1] ? DENW'(-den) : DENW'(den);
            rem_next  = '0;
            neg_next  = num[NUMW-1] ^ den[DENW-1];
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                if (trial >= {1'b0, dmag_reg}) begin
                    rem_next  = DENW'(trial - {1'b0, dmag_reg});
                    nmag_next = {nmag_reg[NUMW-2:0], 1'b1};
                end else begin
                    rem_next  = trial[DENW-1:0];
                    nmag_next = {nmag_reg[NUMW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
            end else begin
                quot_next = neg_reg ? -signed'(nmag_reg) : signed'(nmag_reg);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/ncev_datapath.sv =====
// ----------------------------------------------------------------------------
// ncev_datapath
// Knot and control point stores, basis registers, shared multiplier and
// divider, accumulators and result register.
// ----------------------------------------------------------------------------
module ncev_datapath
    import ncev_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DEGREE = 7,
    parameter int FRAC_BITS  = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  ncev_in_t  s_item,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output ncev_out_t m_item
);

    localparam int KDEPTH = MAX_POINTS + MAX_DEGREE + 1;
    localparam int KIW    = $clog2(KDEPTH);
    localparam int PIW    = $clog2(MAX_POINTS);
    localparam int NBD    = MAX_DEGREE + 1;
    localparam int DIW    = $clog2(NBD);
    localparam int NUMW   = 36 + FRAC_BITS;
    localparam int DENW   = 34;
    localparam int PW     = 66;
    localparam int AW     = 68;
    localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;

    logic signed [31:0] knot_mem [KDEPTH];
    logic [3:0][31:0]   cp_mem   [MAX_POINTS];

    ncev_in_t           in_reg;
    logic signed [31:0] knot_q;
    logic [3:0][31:0]   cp_q;
    logic [3:0][31:0]   cpa_reg;
    logic signed [31:0] klo_reg;
    logic signed [32:0] kd_reg;
    logic signed [32:0] left_reg  [NBD];
    logic signed [32:0] right_reg [NBD];
    logic signed [31:0] nb_reg    [NBD];
    logic signed [31:0] tq_reg;
    logic signed [PW-1:0] saved_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg [4];
    logic               zf_reg;
    logic               sf_reg;
    ncev_out_t          out_reg;

    logic [DIW-1:0]     li, ri, ni;
    logic signed [32:0] mul_a, mul_b;
    logic signed [32:0] diff;
    logic signed [PW-1:0] prod_sh;
    logic signed [DENW-1:0] den;
    logic               div_start;
    logic signed [NUMW-1:0] div_num;
    logic signed [DENW-1:0] div_den;
    logic               div_done;
    logic signed [NUMW-1:0] div_quot;
    sat_t               sat_upd, sat_top, sat_q;
    sat_t               sat_o [4];
    logic               out_ovf;

    assign li = cmd.lidx[DIW-1:0];
    assign ri = cmd.ridx[DIW-1:0];
    assign ni = cmd.nidx[DIW-1:0];

    always_ff @(posedge aclk) begin
        if (in_reg.operation == OP_WR_KNOT && cmd.op == DP_WRITE
                && int'(in_reg.entry_index) < KDEPTH) begin
            knot_mem[KIW'(in_reg.entry_index)] <= in_reg.knot_value;
        end
        if (cmd.krd) begin
            knot_q <= knot_mem[cmd.kaddr[KIW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_reg.operation == OP_WR_POINT && cmd.op == DP_WRITE
                && int'(in_reg.entry_index) < MAX_POINTS) begin
            cp_mem[PIW'(in_reg.entry_index)] <= {in_reg.coord_weight, in_reg.coord_z,
                                                 in_reg.coord_y, in_reg.coord_x};
        end
        if (cmd.crd) begin
            cp_q <= cp_mem[cmd.caddr[PIW-1:0]];
        end
    end

    ncev_div #(
        .NUMW (NUMW),
        .DENW (DENW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        diff    = 33'(signed'(cp_q[cmd.comp])) - 33'(signed'(cpa_reg[cmd.comp]));
        prod_sh = prod_reg >>> FRAC_BITS;
        den     = DENW'(right_reg[ri]) + DENW'(left_reg[li]);
        unique case (cmd.msel)
            MS_RT: begin
                mul_a = right_reg[ri];
                mul_b = 33'(tq_reg);
            end
            MS_LT: begin
                mul_a = left_reg[li];
                mul_b = 33'(tq_reg);
            end
            MS_NB_CP: begin
                mul_a = 33'(nb_reg[ni]);
                mul_b = 33'(signed'(cp_q[cmd.comp]));
            end
            MS_NB_Q: begin
                mul_a = 33'(nb_reg[ni]);
                mul_b = 33'(tq_reg);
            end
            MS_DIFF: begin
                mul_a = diff;
                mul_b = signed'({30'd0, cmd.deg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        div_start = (cmd.op == DP_BDIV && den != '0) || (cmd.op == DP_DDIV && kd_reg != '0);
        if (cmd.op == DP_DDIV) begin
            div_num = NUMW'(signed'(prod_reg[35:0])) <<< FRAC_BITS;
            div_den = DENW'(kd_reg);
        end else begin
            div_num = NUMW'(nb_reg[ni]) <<< FRAC_BITS;
            div_den = den;
        end
        sat_upd = sat32(SATW'(saved_reg) + SATW'(prod_sh));
        sat_top = sat32(SATW'(saved_reg));
        sat_q   = sat32(SATW'(div_quot));
        for (int c = 0; c < 4; c++) begin
            sat_o[c] = sat32(SATW'(acc_reg[c]));
        end
        out_ovf = sat_o[0].ovf | sat_o[1].ovf | sat_o[2].ovf | sat_o[3].ovf;
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        unique case (cmd.op)
            DP_LOAD: begin
                in_reg <= s_item;
                zf_reg <= 1'b0;
                sf_reg <= 1'b0;
                for (int c = 0; c < 4; c++) begin
                    acc_reg[c] <= '0;
                end
            end
            DP_NB_INIT: begin
                nb_reg[0] <= FX_ONE;
            end
            DP_SET_LEFT: begin
                left_reg[li] <= 33'(in_reg.curve_param) - 33'(knot_q);
            end
            DP_SET_RIGHT: begin
                right_reg[ri] <= 33'(knot_q) - 33'(in_reg.curve_param);
                saved_reg     <= '0;
            end
            DP_BDIV: begin
                if (den == '0) begin
                    zf_reg <= 1'b1;
                    tq_reg <= '0;
                end
            end
            DP_DDIV: begin
                if (kd_reg == '0) begin
                    zf_reg <= 1'b1;
                    tq_reg <= '0;
                end
            end
            DP_TSAVE, DP_QSAVE: begin
                tq_reg <= sat_q.val;
                sf_reg <= sf_reg | sat_q.ovf;
            end
            DP_NB_UPD: begin
                nb_reg[ni] <= sat_upd.val;
                sf_reg     <= sf_reg | sat_upd.ovf;
            end
            DP_SAVED: begin
                saved_reg <= prod_sh;
            end
            DP_NB_TOP: begin
                nb_reg[ni] <= sat_top.val;
                sf_reg     <= sf_reg | sat_top.ovf;
            end
            DP_KLO: begin
                klo_reg <= knot_q;
                cpa_reg <= cp_q;
            end
            DP_KD: begin
                kd_reg <= 33'(knot_q) - 33'(klo_reg);
            end
            DP_ACC: begin
                acc_reg[cmd.comp] <= acc_reg[cmd.comp] + AW'(prod_sh);
            end
            DP_OUT: begin
                out_reg.result_x      <= sat_o[0].val;
                out_reg.result_y      <= sat_o[1].val;
                out_reg.result_z      <= sat_o[2].val;
                out_reg.result_weight <= sat_o[3].val;
                out_reg.found_span    <= cmd.span[6:0];
                if (zf_reg) begin
                    out_reg.status <= STAT_ZERO_DIV;
                end else if (sf_reg || out_ovf) begin
                    out_reg.status <= STAT_SAT;
                end else begin
                    out_reg.status <= STAT_OK;
                end
            end
            default: begin
            end
        endcase
    end

    assign stat.op        = in_reg.operation;
    assign stat.u_lt_knot = in_reg.curve_param < knot_q;
    assign stat.u_le_knot = in_reg.curve_param <= knot_q;
    assign stat.den_zero  = (den == '0);
    assign stat.kd_zero   = (kd_reg == '0);
    assign stat.div_done  = div_done;
    assign m_item         = out_reg;

endmodule

// ===== rtl/ncev_ctrl.sv =====
// ----------------------------------------------------------------------------
// ncev_ctrl
// Sequencer: configuration registers, span search, basis recurrence,
// accumulation loops and result handshake.
// ----------------------------------------------------------------------------
module ncev_ctrl
    import ncev_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DEGREE = 7
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic [6:0] cfg_data,
    output dp_cmd_t    cmd,
    input  dp_stat_t   stat
);

    ctrl_state_t       state_reg, state_next;
    logic [2:0]        degree_reg;
    logic [6:0]        count_reg;
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] span_reg, span_next;
    logic [ADDR_W-1:0] lo_reg, lo_next;
    logic [ADDR_W-1:0] hi_reg, hi_next;
    logic [DIDX_W-1:0] j_reg, j_next;
    logic [DIDX_W-1:0] r_reg, r_next;
    logic [DIDX_W-1:0] i_reg, i_next;
    logic [DIDX_W-1:0] bd_reg, bd_next;
    logic [1:0]        comp_reg, comp_next;

    logic [ADDR_W-1:0] cnt;
    logic [DIDX_W-1:0] dg;
    logic [DIDX_W-1:0] dg_raw;
    logic [DIDX_W-1:0] bd;
    logic [ADDR_W-1:0] mid;
    logic [ADDR_W-1:0] base;
    logic              deriv;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign deriv     = (stat.op == OP_DERIV);

    always_comb begin
        if (count_reg < 7'd2) begin
            cnt = ADDR_W'(2);
        end else if (int'(count_reg) > MAX_POINTS) begin
            cnt = ADDR_W'(MAX_POINTS);
        end else begin
            cnt = ADDR_W'(count_reg);
        end
        if (degree_reg == 3'd0) begin
            dg_raw = DIDX_W'(1);
        end else if (int'(degree_reg) > MAX_DEGREE) begin
            dg_raw = DIDX_W'(MAX_DEGREE);
        end else begin
            dg_raw = DIDX_W'(degree_reg);
        end
        if (ADDR_W'(dg_raw) > cnt - ADDR_W'(1)) begin
            dg = DIDX_W'(cnt - ADDR_W'(1));
        end else begin
            dg = dg_raw;
        end
        bd   = deriv ? dg - DIDX_W'(1) : dg;
        mid  = ADDR_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
        base = span_reg - ADDR_W'(dg) + ADDR_W'(i_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            degree_reg  <= DEGREE_RST;
            count_reg   <= COUNT_RST;
            m_valid_reg <= 1'b0;
            span_reg    <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            j_reg       <= '0;
            r_reg       <= '0;
            i_reg       <= '0;
            bd_reg      <= '0;
            comp_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            span_reg    <= span_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            j_reg       <= j_next;
            r_reg       <= r_next;
            i_reg       <= i_next;
            bd_reg      <= bd_next;
            comp_reg    <= comp_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_DEGREE) begin
                    degree_reg <= cfg_data[2:0];
                end else begin
                    count_reg <= cfg_data;
                end
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        span_next    = span_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        j_next       = j_reg;
        r_next       = r_reg;
        i_next       = i_reg;
        bd_next      = bd_reg;
        comp_next    = comp_reg;

        cmd        = '0;
        cmd.op     = DP_NOP;
        cmd.msel   = MS_RT;
        cmd.comp   = comp_reg;
        cmd.deg    = dg;
        cmd.span   = span_reg;
        cmd.lidx   = j_reg - r_reg;
        cmd.ridx   = r_reg + DIDX_W'(1);
        cmd.nidx   = r_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = DP_LOAD;
                    span_next  = '0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.op == OP_WR_KNOT || stat.op == OP_WR_POINT) begin
                    state_next = S_WRITE;
                end else begin
                    cmd.krd    = 1'b1;
                    cmd.kaddr  = cnt;
                    state_next = S_SPAN_HI;
                end
            end
            S_WRITE: begin
                cmd.op     = DP_WRITE;
                state_next = S_FIN;
            end
            S_SPAN_HI: begin
                if (!stat.u_lt_knot) begin
                    span_next  = cnt - ADDR_W'(1);
                    state_next = S_NB_INIT;
                end else begin
                    cmd.krd    = 1'b1;
                    cmd.kaddr  = ADDR_W'(dg);
                    state_next = S_SPAN_CHK;
                end
            end
            S_SPAN_CHK: begin
                if (stat.u_le_knot) begin
                    span_next  = ADDR_W'(dg);
                    state_next = S_NB_INIT;
                end else begin
                    lo_next    = ADDR_W'(dg);
                    hi_next    = cnt;
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (hi_reg - lo_reg > ADDR_W'(1)) begin
                    cmd.krd    = 1'b1;
                    cmd.kaddr  = mid;
                    state_next = S_SRCH_CMP;
                end else begin
                    span_next  = lo_reg;
                    state_next = S_NB_INIT;
                end
            end
            S_SRCH_CMP: begin
                if (stat.u_lt_knot) begin
                    hi_next = mid;
                end else begin
                    lo_next = mid;
                end
                state_next = S_SRCH_RD;
            end
            S_NB_INIT: begin
                cmd.op  = DP_NB_INIT;
                bd_next = bd;
                j_next  = DIDX_W'(1);
                i_next  = '0;
                if (bd == '0) begin
                    state_next = S_DK_RD;
                end else begin
                    state_next = S_LR_RD;
                end
            end
            S_LR_RD: begin
                cmd.krd    = 1'b1;
                cmd.kaddr  = span_reg + ADDR_W'(1) - ADDR_W'(j_reg);
                state_next = S_LEFT;
            end
            S_LEFT: begin
                cmd.op     = DP_SET_LEFT;
                cmd.lidx   = j_reg;
                cmd.krd    = 1'b1;
                cmd.kaddr  = span_reg + ADDR_W'(j_reg);
                state_next = S_RIGHT;
            end
            S_RIGHT: begin
                cmd.op     = DP_SET_RIGHT;
                cmd.ridx   = j_reg;
                r_next     = '0;
                state_next = S_BDIV;
            end
            S_BDIV: begin
                cmd.op = DP_BDIV;
                if (stat.den_zero) begin
                    state_next = S_BMUL_R;
                end else begin
                    state_next = S_BDIV_WAIT;
                end
            end
            S_BDIV_WAIT: begin
                if (stat.div_done) begin
                    state_next = S_BTSAVE;
                end
            end
            S_BTSAVE: begin
                cmd.op     = DP_TSAVE;
                state_next = S_BMUL_R;
            end
            S_BMUL_R: begin
                cmd.mul_en = 1'b1;
                cmd.msel   = MS_RT;
                state_next = S_BNB;
            end
            S_BNB: begin
                cmd.op     = DP_NB_UPD;
                cmd.mul_en = 1'b1;
                cmd.msel   = MS_LT;
                state_next = S_BSAVED;
            end
            S_BSAVED: begin
                cmd.op = DP_SAVED;
                if (r_reg + DIDX_W'(1) < j_reg) begin
                    r_next     = r_reg + DIDX_W'(1);
                    state_next = S_BDIV;
                end else begin
                    state_next = S_BTOP;
                end
            end
            S_BTOP: begin
                cmd.op   = DP_NB_TOP;
                cmd.nidx = j_reg;
                if (j_reg < bd_reg) begin
                    j_next     = j_reg + DIDX_W'(1);
                    state_next = S_LR_RD;
                end else begin
                    i_next     = '0;
                    state_next = deriv ? S_DK_RD : S_PT_RD;
                end
            end
            S_PT_RD: begin
                cmd.crd    = 1'b1;
                cmd.caddr  = base;
                comp_next  = '0;
                state_next = S_PT_MUL;
            end
            S_PT_MUL: begin
                cmd.mul_en = 1'b1;
                cmd.msel   = MS_NB_CP;
                cmd.nidx   = i_reg;
                state_next = S_PT_ACC;
            end
            S_PT_ACC: begin
                cmd.op = DP_ACC;
                if (comp_reg != 2'd3) begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_PT_MUL;
                end else if (i_reg < dg) begin
                    i_next     = i_reg + DIDX_W'(1);
                    state_next = S_PT_RD;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_DK_RD: begin
                cmd.krd    = 1'b1;
                cmd.kaddr  = base + ADDR_W'(1);
                cmd.crd    = 1'b1;
                cmd.caddr  = base;
                state_next = S_DK_LO;
            end
            S_DK_LO: begin
                cmd.op     = DP_KLO;
                cmd.krd    = 1'b1;
                cmd.kaddr  = base + ADDR_W'(dg) + ADDR_W'(1);
                cmd.crd    = 1'b1;
                cmd.caddr  = base + ADDR_W'(1);
                comp_next  = '0;
                state_next = S_DK_KD;
            end
            S_DK_KD: begin
                cmd.op     = DP_KD;
                state_next = S_DM_DIFF;
            end
            S_DM_DIFF: begin
                cmd.mul_en = 1'b1;
                cmd.msel   = MS_DIFF;
                state_next = S_DM_DIV;
            end
            S_DM_DIV: begin
                cmd.op = DP_DDIV;
                if (stat.kd_zero) begin
                    state_next = S_DM_MUL;
                end else begin
                    state_next = S_DM_WAIT;
                end
            end
            S_DM_WAIT: begin
                if (stat.div_done) begin
                    state_next = S_DM_QSAVE;
                end
            end
            S_DM_QSAVE: begin
                cmd.op     = DP_QSAVE;
                state_next = S_DM_MUL;
            end
            S_DM_MUL: begin
                cmd.mul_en = 1'b1;
                cmd.msel   = MS_NB_Q;
                cmd.nidx   = i_reg;
                state_next = S_DM_ACC;
            end
            S_DM_ACC: begin
                cmd.op = DP_ACC;
                if (comp_reg != 2'd3) begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_DM_DIFF;
                end else if (i_reg + DIDX_W'(1) < dg) begin
                    i_next     = i_reg + DIDX_W'(1);
                    state_next = S_DK_RD;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = DP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> (state_reg == S_BDIV_WAIT || state_reg == S_DM_WAIT))
        else $error("divider finished outside a wait state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_NB_INIT) |-> (span_reg >= ADDR_W'(dg) && span_reg < cnt))
        else $error("span outside degree .. count-1");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SRCH_RD) |-> (lo_reg < hi_reg))
        else $error("search bounds crossed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside finish state");

endmodule

// ===== rtl/nurbs_curve_evaluator.sv =====
// ----------------------------------------------------------------------------
// nurbs_curve_evaluator
// NURBS curve point and first-derivative evaluator over loaded knot and
// homogeneous control point stores, signed fixed point with saturation.
// ----------------------------------------------------------------------------
// Writes: an accepted write is decoded, stored and then reported as a result.
// Evaluate: a span search (end checks, then binary search), D(D+1)/2 basis
//   divisions (shared one-bit-per-cycle divider), then a read and 4 MACs per point.
// Derivative: basis of degree D-1, plus 4*D divisions and 8*D multiplies.
// One item in flight; a new item is taken while the last result waits.
// Reset (aresetn low, synchronous) clears control and sets degree 3, count 4.
module nurbs_curve_evaluator
    import ncev_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DEGREE = 7,
    parameter int FRAC_BITS  = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ncev_in_t   s_payload,
    output logic       m_valid,
    input  logic       m_ready,
    output ncev_out_t  m_payload,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic [6:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ncev_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    ncev_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_payload),
        .cmd     (cmd),
        .stat    (stat),
        .m_item  (m_payload)
    );

endmodule

// ===== dv/nurbs_curve_evaluator_tb.sv =====
// ----------------------------------------------------------------------------
// nurbs_curve_evaluator_tb
// Self-checking bench for the NURBS curve evaluator. Loads knot and control
// point stores, sweeps degree and point count settings, evaluates points and
// first derivatives and checks every result against a cycle-free predictor
// of the fixed-point curve arithmetic. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module nurbs_curve_evaluator_tb;
    import ncev_pkg::*;

    typedef logic signed [95:0] wide_t;
    typedef logic signed [31:0] fx_t;

    localparam int NKNOT = 72;
    localparam int NPT   = 64;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    ncev_in_t   s_payload = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    ncev_out_t  m_payload;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [0:0] cfg_index = CFG_DEGREE;
    logic [6:0] cfg_data = '0;

    nurbs_curve_evaluator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // shadow of the block
    fx_t        knot_mem [0:NKNOT-1];
    fx_t        point_mem [0:NPT-1][0:3];
    logic [2:0] degree_reg = DEGREE_RST;
    logic [6:0] count_reg = COUNT_RST;

    ncev_in_t  pending_items[$];
    ncev_out_t expected_points[$];
    int        errors = 0;

    function automatic fx_t clip32(input wide_t v, inout bit ovf);
        if (v > wide_t'(32'sh7FFF_FFFF)) begin
            ovf = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < wide_t'(32'sh8000_0000)) begin
            ovf = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic ncev_out_t eval_curve(input ncev_in_t it);
        ncev_out_t r;
        wide_t     acc [0:3];
        wide_t     lft [0:7];
        wide_t     rgt [0:7];
        fx_t       nb [0:7];
        wide_t     u, saved, den, t, kd, diff, q;
        bit        zf, sf;
        int        cnt, dg, bd, span, lo, hi, mid, jj, idx;
        r = '0;
        zf = 0;
        sf = 0;
        idx = it.entry_index;
        if (it.operation == OP_WR_KNOT) begin
            if (idx < NKNOT) knot_mem[idx] = it.knot_value;
            return r;
        end
        if (it.operation == OP_WR_POINT) begin
            if (idx < NPT) begin
                point_mem[idx][0] = it.coord_x;
                point_mem[idx][1] = it.coord_y;
                point_mem[idx][2] = it.coord_z;
                point_mem[idx][3] = it.coord_weight;
            end
            return r;
        end
        cnt = count_reg;
        if (cnt < 2) cnt = 2;
        if (cnt > NPT) cnt = NPT;
        dg = degree_reg;
        if (dg < 1) dg = 1;
        if (dg > cnt - 1) dg = cnt - 1;
        u = it.curve_param;
        if (u >= knot_mem[cnt]) begin
            span = cnt - 1;
        end else if (u <= knot_mem[dg]) begin
            span = dg;
        end else begin
            lo = dg;
            hi = cnt;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (u < knot_mem[mid]) hi = mid;
                else lo = mid;
            end
            span = lo;
        end
        bd = (it.operation == OP_EVAL) ? dg : dg - 1;
        nb[0] = 32'sh0001_0000;
        for (int j = 1; j <= bd; j++) begin
            saved = 0;
            lft[j] = u - knot_mem[span + 1 - j];
            rgt[j] = wide_t'(knot_mem[span + j]) - u;
            for (int k = 0; k < j; k++) begin
                den = rgt[k + 1] + lft[j - k];
                if (den == 0) begin
                    zf = 1;
                    t = 0;
                end else begin
                    t = clip32((wide_t'(nb[k]) <<< 16) / den, sf);
                end
                nb[k] = clip32(saved + ((rgt[k + 1] * t) >>> 16), sf);
                saved = (lft[j - k] * t) >>> 16;
            end
            nb[j] = clip32(saved, sf);
        end
        for (int c = 0; c < 4; c++) acc[c] = 0;
        if (it.operation == OP_EVAL) begin
            for (int i = 0; i <= dg; i++)
                for (int c = 0; c < 4; c++)
                    acc[c] += (wide_t'(nb[i]) * wide_t'(point_mem[span - dg + i][c])) >>> 16;
        end else begin
            for (int i = 0; i < dg; i++) begin
                jj = span - dg + i;
                kd = wide_t'(knot_mem[jj + dg + 1]) - wide_t'(knot_mem[jj + 1]);
                for (int c = 0; c < 4; c++) begin
                    diff = wide_t'(point_mem[jj + 1][c]) - wide_t'(point_mem[jj][c]);
                    if (kd == 0) begin
                        zf = 1;
                        q = 0;
                    end else begin
                        q = clip32(((diff * wide_t'(dg)) <<< 16) / kd, sf);
                    end
                    acc[c] += (wide_t'(nb[i]) * q) >>> 16;
                end
            end
        end
        r.result_x      = clip32(acc[0], sf);
        r.result_y      = clip32(acc[1], sf);
        r.result_z      = clip32(acc[2], sf);
        r.result_weight = clip32(acc[3], sf);
        r.found_span    = span[6:0];
        r.status        = zf ? STAT_ZERO_DIV : (sf ? STAT_SAT : STAT_OK);
        return r;
    endfunction

    // driver: bursts with random gaps
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) expected_points.push_back(eval_curve(s_payload));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    s_valid <= 1'b1;
                    s_payload <= pending_items.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // monitor: receiver stalls on its own pattern
    int stall_cyc = 0;
    int stall_mode = 0;
    ncev_out_t want;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    report("unexpected transaction", 0, 0);
                end else begin
                    want = expected_points.pop_front();
                    if (m_payload.result_x != want.result_x)
                        report("result_x", m_payload.result_x, want.result_x);
                    if (m_payload.result_y != want.result_y)
                        report("result_y", m_payload.result_y, want.result_y);
                    if (m_payload.result_z != want.result_z)
                        report("result_z", m_payload.result_z, want.result_z);
                    if (m_payload.result_weight != want.result_weight)
                        report("result_weight", m_payload.result_weight, want.result_weight);
                    if (m_payload.found_span != want.found_span)
                        report("found_span", m_payload.found_span, want.found_span);
                    if (m_payload.status != want.status)
                        report("status", m_payload.status, want.status);
                end
            end
            stall_cyc++;
            if (stall_cyc % 300 == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ((stall_cyc / 7) % 2 == 0);
            endcase
        end
    end

    // stimulus side
    longint gen_knot [0:NKNOT-1];
    int     total_items = 0;

    function automatic ncev_in_t rand_item(input logic [1:0] op);
        ncev_in_t it;
        it.operation    = op;
        it.entry_index  = $urandom;
        it.knot_value   = $urandom;
        it.coord_x      = $urandom;
        it.coord_y      = $urandom;
        it.coord_z      = $urandom;
        it.coord_weight = $urandom;
        it.curve_param  = $urandom;
        return it;
    endfunction

    task automatic put_knot(input int idx, input fx_t v);
        ncev_in_t it;
        it = rand_item(OP_WR_KNOT);
        it.entry_index = idx;
        it.knot_value = v;
        if (idx < NKNOT) gen_knot[idx] = v;
        pending_items.push_back(it);
        total_items++;
    endtask

    task automatic put_point(input int idx, input int kind);
        ncev_in_t it;
        it = rand_item(OP_WR_POINT);
        it.entry_index = idx;
        if (kind == 0) begin
            it.coord_x = $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
            it.coord_y = $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
            it.coord_z = $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
            it.coord_weight = 32'sh8000 + $urandom_range(0, 32'h1_0000);
        end else if (kind == 2) begin
            it.coord_x = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            it.coord_y = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            it.coord_z = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            it.coord_weight = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end
        pending_items.push_back(it);
        total_items++;
    endtask

    task automatic put_eval(input logic [1:0] op, input fx_t u);
        ncev_in_t it;
        it = rand_item(op);
        it.curve_param = u;
        pending_items.push_back(it);
        total_items++;
    endtask

    // knot vector: clamped uniform, sorted with repeats, wide sorted or unsorted
    task automatic load_knots(input int nk, input int dg, input int mode);
        longint v, step;
        v = $signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
        step = $urandom_range(1, 32'h2_0000);
        if (mode == 2) begin
            v = -64'sd2147483648 + $urandom_range(0, 32'h1000_0000);
            step = 32'd4294967295 / nk;
        end
        for (int i = 0; i < nk; i++) begin
            case (mode)
                0: put_knot(i, v + step * ((i <= dg) ? 0 : (i >= nk - dg - 1) ?
                            (nk - 2 * dg - 1) : (i - dg)));
                1: begin
                    put_knot(i, v);
                    v += $urandom_range(0, 3) * 32'sh4000;
                end
                2: begin
                    put_knot(i, (v > 2147483647) ? 32'sh7FFF_FFFF : fx_t'(v));
                    v += $urandom_range(0, step);
                end
                default: put_knot(i, $urandom);
            endcase
        end
    endtask

    function automatic fx_t pick_param(input int dg, input int cnt);
        longint lo, hi;
        lo = gen_knot[dg];
        hi = gen_knot[cnt];
        case ($urandom_range(0, 9))
            0: return gen_knot[$urandom_range(0, cnt + dg)];
            1: return $urandom;
            2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: begin
                if (hi <= lo) return lo;
                return lo + $urandom_range(0, hi - lo);
            end
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || expected_points.size() != 0)
            @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [0:0] idx, input logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_DEGREE) degree_reg = val[2:0];
        else count_reg = val;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(input int deg_w, input int cnt_w, input int n_eval,
                             input int kmode, input int pkind);
        int cnt, dg;
        wait_idle();
        cfg_write(CFG_DEGREE, deg_w);
        cfg_write(CFG_COUNT, cnt_w);
        cnt = (count_reg < 2) ? 2 : (count_reg > NPT) ? NPT : count_reg;
        dg = (degree_reg < 1) ? 1 : degree_reg;
        if (dg > cnt - 1) dg = cnt - 1;
        load_knots(cnt + dg + 1, dg, kmode);
        for (int i = 0; i < cnt; i++)
            put_point(i, (pkind == 3) ? $urandom_range(0, 2) : pkind);
        for (int i = 0; i < n_eval; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                if ($urandom_range(0, 1)) put_knot($urandom_range(NKNOT, 127), $urandom);
                else put_point($urandom_range(NPT, 127), 1);
            end
            put_eval($urandom_range(0, 1) ? OP_EVAL : OP_DERIV, pick_param(dg, cnt));
        end
    endtask

    initial begin
        int big;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill both stores under the reset setting
        load_knots(NKNOT, 3, 0);
        for (int i = 0; i < NPT; i++) put_point(i, 0);
        put_knot(127, 32'sh7FFF_FFFF);
        put_point(127, 2);
        put_knot(NKNOT, 32'sh8000_0000);
        put_point(NPT, 1);
        put_eval(OP_EVAL, 32'sh8000_0000);
        put_eval(OP_DERIV, 32'sh7FFF_FFFF);
        put_eval(OP_EVAL, gen_knot[3]);
        put_eval(OP_DERIV, gen_knot[4]);
        for (int i = 0; i < 4; i++) put_point(i, 2);
        put_eval(OP_EVAL, gen_knot[3] + 1);
        put_eval(OP_DERIV, gen_knot[3] + 1);
        put_knot(4, 32'sh8000_0000);
        put_knot(5, 32'sh7FFF_FFFF);
        put_eval(OP_EVAL, 0);
        put_eval(OP_DERIV, 0);

        // extreme settings
        run_phase(7, 64, 6, 0, 0);
        run_phase(0, 0, 10, 1, 3);
        run_phase(1, 2, 10, 3, 1);
        run_phase(7, 127, 6, 2, 3);
        run_phase(6, 100, 4, 3, 2);
        run_phase(7, 5, 10, 1, 0);

        while (total_items < 1650) begin
            big = ($urandom_range(0, 9) == 0);
            run_phase(big ? $urandom_range(0, 7) : $urandom_range(1, 3),
                      big ? $urandom_range(0, 127) : $urandom_range(2, 10),
                      big ? 8 : $urandom_range(30, 70),
                      $urandom_range(0, 3), $urandom_range(0, 3));
        end

        wait_idle();
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS nurbs_curve_evaluator");
        end else begin
            $display("FAIL nurbs_curve_evaluator");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("FAIL nurbs_curve_evaluator");
        $finish;
    end

endmodule
